### design/dsq_pkg.sv
// ----------------------------------------------------------------------------
// dsq_pkg
// Shared constants, codes and controller/datapath interface types of the
// delta-list sleep queue.
// ----------------------------------------------------------------------------
package dsq_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int MAX_RESULTS = 16;

    // Entry index, and counters that must also hold the depth itself.
    localparam int IDX_W   = $clog2(MAX_ENTRIES);
    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int RES_W   = $clog2(MAX_RESULTS + 1);
    localparam int TID_W   = 8;
    localparam int DELTA_W = 16;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_TICK   = 2'd1,
        OP_REMOVE = 2'd2,
        OP_NONE   = 2'd3
    } dsq_op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } dsq_status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_WALK,
        S_REM_WALK,
        S_REM_DROP,
        S_TICK_DEC,
        S_TICK_SCAN,
        S_RESP
    } dsq_state_t;

    typedef struct packed {
        logic        load;        // capture a new input word
        logic        ins_step;    // insert walk: add delta, next entry
        logic        ins_place;   // insert: open a slot at the pointer
        logic        rem_step;    // remove walk: next entry
        logic        rem_hit;     // remove: keep the matched delta, next entry
        logic        rem_drop;    // remove: close the slot behind the pointer
        logic        tick_dec;    // lower the head delta
        logic        tick_pop;    // emit the head and drop it
        logic        resp_load;   // emit a single closing result word
        logic        set_status;
        dsq_status_t status_code;
    } dsq_cmd_t;

    typedef struct packed {
        logic full;
        logic at_end;
        logic walk_go;
        logic id_match;
        logic head_expired;
        logic head_last;
        logic out_free;
    } dsq_stat_t;

endpackage

### design/delta_sleep_queue_top.sv
// ----------------------------------------------------------------------------
// delta_sleep_queue_top
// Sleep queue kept as a delta list of up to MAX_ENTRIES threads.
//
// Channel  Dir  Handshake          Payload
// s_axis   in   s_tvalid/s_tready  tuser: opcode; tdata: thread_id, sleep_ticks
// m_axis   out  m_tvalid/m_tready  tuser: woke, status; tdata: woken_id; tlast
//
// One word is in work at a time. Insert and remove walk the list one stored
// entry per cycle. A tick first lowers the head delta, then pops expired
// heads as woken results, or emits one closing result when none wakes; each
// result waits in the output register until taken, stalling the pop sequence.
// The queue is empty after reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module delta_sleep_queue_top
    import dsq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] thread_id, [23:8] sleep_ticks
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] woken_id
    output logic [2:0]  m_tuser,   // [0] woke, [2:1] status
    output logic        m_tlast
);

    dsq_cmd_t    cmd;
    dsq_stat_t   stat;
    logic        woke;
    dsq_status_t status;

    dsq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .in_opcode (s_tuser),
        .s_tready  (s_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dsq_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_thread_id   (s_tdata[7:0]),
        .in_sleep_ticks (s_tdata[23:8]),
        .m_tready       (m_tready),
        .m_tvalid       (m_tvalid),
        .m_woken_id     (m_tdata),
        .m_woke         (woke),
        .m_status       (status),
        .m_tlast        (m_tlast)
    );

    assign m_tuser = {status, woke};

endmodule

### design/dsq_ctrl.sv
// ----------------------------------------------------------------------------
// dsq_ctrl
// Sequencer of the sleep queue: walks insert and remove one entry per cycle
// and pops expired heads on a tick.
// ----------------------------------------------------------------------------
module dsq_ctrl
    import dsq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic [1:0] in_opcode,
    output logic       s_tready,
    input  dsq_stat_t  stat,
    output dsq_cmd_t   cmd
);

    dsq_state_t state_reg;
    dsq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (dsq_op_t'(in_opcode))
                        OP_INSERT: state_next = S_INS_WALK;
                        OP_TICK:   state_next = S_TICK_DEC;
                        OP_REMOVE: state_next = S_REM_WALK;
                        default:   state_next = S_RESP;
                    endcase
                end
            end
            S_INS_WALK:
            begin
                if (stat.full || stat.at_end || !stat.walk_go)
                begin
                    state_next = S_RESP;
                end
            end
            S_REM_WALK:
            begin
                if (stat.at_end)
                begin
                    state_next = S_RESP;
                end
                else if (stat.id_match)
                begin
                    state_next = S_REM_DROP;
                end
            end
            S_REM_DROP:
            begin
                state_next = S_RESP;
            end
            S_TICK_DEC:
            begin
                state_next = S_TICK_SCAN;
            end
            S_TICK_SCAN:
            begin
                if (stat.out_free && (!stat.head_expired || stat.head_last))
                begin
                    state_next = S_IDLE;
                end
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.status_code = ST_OK;
        s_tready    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_INS_WALK:
            begin
                if (stat.full)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_FULL;
                end
                else if (!stat.at_end && stat.walk_go)
                begin
                    cmd.ins_step = 1'b1;
                end
                else
                begin
                    cmd.ins_place = 1'b1;
                end
            end
            S_REM_WALK:
            begin
                if (stat.at_end)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_NOT_FOUND;
                end
                else if (stat.id_match)
                begin
                    cmd.rem_hit = 1'b1;
                end
                else
                begin
                    cmd.rem_step = 1'b1;
                end
            end
            S_REM_DROP:
            begin
                cmd.rem_drop = 1'b1;
            end
            S_TICK_DEC:
            begin
                cmd.tick_dec = 1'b1;
            end
            S_TICK_SCAN:
            begin
                if (stat.out_free)
                begin
                    if (stat.head_expired)
                    begin
                        cmd.tick_pop = 1'b1;
                    end
                    else
                    begin
                        cmd.resp_load = 1'b1;
                    end
                end
            end
            S_RESP:
            begin
                cmd.resp_load = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

### design/dsq_datapath.sv
// ----------------------------------------------------------------------------
// dsq_datapath
// Entry registers of the delta list, walk pointer and running sum, and the
// output register of the result stream.
// ----------------------------------------------------------------------------
module dsq_datapath
    import dsq_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  dsq_cmd_t             cmd,
    output dsq_stat_t            stat,
    input  logic [TID_W-1:0]     in_thread_id,
    input  logic [DELTA_W-1:0]   in_sleep_ticks,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [TID_W-1:0]     m_woken_id,
    output logic                 m_woke,
    output dsq_status_t          m_status,
    output logic                 m_tlast
);

    logic [TID_W-1:0]   thread_reg [MAX_ENTRIES];
    logic [DELTA_W-1:0] delta_reg  [MAX_ENTRIES];
    logic [TID_W-1:0]   thread_up  [MAX_ENTRIES];
    logic [DELTA_W-1:0] delta_up   [MAX_ENTRIES];
    logic [TID_W-1:0]   thread_dn  [MAX_ENTRIES];
    logic [DELTA_W-1:0] delta_dn   [MAX_ENTRIES];

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   ptr_reg;
    logic [RES_W-1:0]   n_reg;
    logic [DELTA_W-1:0] sum_reg;
    logic [DELTA_W-1:0] acc_reg;
    logic [DELTA_W-1:0] ticks_reg;
    logic [TID_W-1:0]   id_reg;
    dsq_status_t        status_reg;

    logic               out_valid_reg;
    logic [TID_W-1:0]   out_id_reg;
    logic               out_woke_reg;
    dsq_status_t        out_status_reg;
    logic               out_last_reg;

    logic [DELTA_W-1:0] cur_delta;
    logic [TID_W-1:0]   cur_thread;
    logic [DELTA_W:0]   walk_sum;
    logic [DELTA_W:0]   merge_sum;
    logic [DELTA_W-1:0] merged;
    logic [DELTA_W-1:0] new_delta;
    logic [DELTA_W-1:0] follow_delta;

    // Neighbor views for the shifts; the end entries keep their own value.
    always_comb
    begin
        for (int i = 1; i < MAX_ENTRIES; i++)
        begin
            thread_up[i] = thread_reg[i-1];
            delta_up[i]  = delta_reg[i-1];
        end
        thread_up[0] = thread_reg[0];
        delta_up[0]  = delta_reg[0];
        for (int i = 0; i < MAX_ENTRIES - 1; i++)
        begin
            thread_dn[i] = thread_reg[i+1];
            delta_dn[i]  = delta_reg[i+1];
        end
        thread_dn[MAX_ENTRIES-1] = thread_reg[MAX_ENTRIES-1];
        delta_dn[MAX_ENTRIES-1]  = delta_reg[MAX_ENTRIES-1];
    end

    assign cur_delta    = delta_reg[ptr_reg[IDX_W-1:0]];
    assign cur_thread   = thread_reg[ptr_reg[IDX_W-1:0]];
    assign walk_sum     = {1'b0, sum_reg} + {1'b0, cur_delta};
    assign new_delta    = ticks_reg - sum_reg;
    assign follow_delta = cur_delta - new_delta;
    assign merge_sum    = {1'b0, cur_delta} + {1'b0, acc_reg};
    assign merged       = merge_sum[DELTA_W] ? {DELTA_W{1'b1}} : merge_sum[DELTA_W-1:0];

    assign stat.full         = (count_reg == CNT_W'(MAX_ENTRIES));
    assign stat.at_end       = (ptr_reg == count_reg);
    assign stat.walk_go      = (walk_sum <= {1'b0, ticks_reg});
    assign stat.id_match     = (cur_thread == id_reg);
    assign stat.head_expired = (count_reg != '0) && (delta_reg[0] == '0)
                             && (n_reg < RES_W'(MAX_RESULTS));
    assign stat.head_last    = !(((n_reg + RES_W'(1)) < RES_W'(MAX_RESULTS))
                             && (count_reg > CNT_W'(1)) && (delta_reg[1] == '0));
    assign stat.out_free     = !out_valid_reg || m_tready;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (cmd.ins_place)
            begin
                if (CNT_W'(i) > ptr_reg)
                begin
                    thread_reg[i] <= thread_up[i];
                    delta_reg[i]  <= (CNT_W'(i) == ptr_reg + CNT_W'(1)) ?
                                     follow_delta : delta_up[i];
                end
                else if (CNT_W'(i) == ptr_reg)
                begin
                    thread_reg[i] <= id_reg;
                    delta_reg[i]  <= new_delta;
                end
            end
            else if (cmd.rem_drop)
            begin
                // The pointer sits one past the matched entry; the follower's
                // delta absorbs the removed one.
                if (CNT_W'(i + 1) >= ptr_reg)
                begin
                    thread_reg[i] <= thread_dn[i];
                    delta_reg[i]  <= (CNT_W'(i + 1) == ptr_reg) ? merged : delta_dn[i];
                end
            end
            else if (cmd.tick_pop)
            begin
                thread_reg[i] <= thread_dn[i];
                delta_reg[i]  <= delta_dn[i];
            end
            else if (cmd.tick_dec && i == 0)
            begin
                if (count_reg != '0 && delta_reg[0] != '0)
                begin
                    delta_reg[0] <= delta_reg[0] - DELTA_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            id_reg     <= in_thread_id;
            ticks_reg  <= (in_sleep_ticks == '0) ? DELTA_W'(1) : in_sleep_ticks;
            sum_reg    <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            if (cmd.ins_step)
            begin
                sum_reg <= walk_sum[DELTA_W-1:0];
            end
            if (cmd.rem_hit)
            begin
                acc_reg <= cur_delta;
            end
            if (cmd.set_status)
            begin
                status_reg <= cmd.status_code;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ptr_reg   <= '0;
            n_reg     <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                ptr_reg <= '0;
                n_reg   <= '0;
            end
            else if (cmd.ins_step || cmd.rem_step || cmd.rem_hit)
            begin
                ptr_reg <= ptr_reg + CNT_W'(1);
            end
            if (cmd.ins_place)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.rem_drop || cmd.tick_pop)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (cmd.tick_pop)
            begin
                n_reg <= n_reg + RES_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.tick_pop || cmd.resp_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tick_pop)
        begin
            out_id_reg     <= thread_reg[0];
            out_woke_reg   <= 1'b1;
            out_status_reg <= ST_OK;
            out_last_reg   <= stat.head_last;
        end
        else if (cmd.resp_load)
        begin
            out_id_reg     <= '0;
            out_woke_reg   <= 1'b0;
            out_status_reg <= status_reg;
            out_last_reg   <= 1'b1;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_woken_id = out_id_reg;
    assign m_woke     = out_woke_reg;
    assign m_status   = out_status_reg;
    assign m_tlast    = out_last_reg;

endmodule

### verif/delta_sleep_queue_top_tb.sv
// ----------------------------------------------------------------------------
// delta_sleep_queue_top_tb
// Self-checking bench for the delta-list sleep queue. A driver sends insert,
// tick, remove and unused-opcode words from a pending queue. A predictor
// keeps its own copy of the delta list and queues the result words that each
// accepted word must cause. A monitor compares every output word with the
// oldest prediction. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module delta_sleep_queue_top_tb;
    import dsq_pkg::*;

    localparam int RANDOM_WORDS   = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 60;

    typedef struct {
        dsq_op_t      op;
        logic [7:0]   id;
        logic [15:0]  ticks;
    } sleep_word_t;

    typedef struct {
        logic [7:0]   id;
        logic         woke;
        dsq_status_t  status;
        logic         last;
    } wake_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // [7:0] thread_id, [23:8] sleep_ticks
    logic [1:0]  s_tuser = '0;   // [1:0] opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // [7:0] woken_id
    logic [2:0]  m_tuser;        // [0] woke, [2:1] status
    logic        m_tlast;

    delta_sleep_queue_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow delta list.
    logic [7:0]  list_thread [MAX_ENTRIES];
    logic [15:0] list_delta  [MAX_ENTRIES];
    int          list_count = 0;

    sleep_word_t words_to_send [$];
    wake_word_t  results_due [$];
    sleep_word_t word_on_bus;
    int          mismatches = 0;
    int          idle_cycles = 0;
    int          send_hold = 0;
    int          send_calm = 0;
    int          recv_hold = 0;
    int          recv_calm = 0;

    function automatic int gap_cycles(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function void drop_entry(int pos);
        for (int i = pos; i + 1 < list_count; i++)
        begin
            list_thread[i] = list_thread[i + 1];
            list_delta[i]  = list_delta[i + 1];
        end
        list_count--;
    endfunction

    // Updates the shadow list for one accepted word and queues its results.
    function void advance_sleep_queue(sleep_word_t w);
        int         pos;
        int         sum;
        int         want;
        int         nd;
        int         merged;
        int         n;
        wake_word_t res;
        res = '{id: 8'd0, woke: 1'b0, status: ST_OK, last: 1'b1};
        case (w.op)
            OP_INSERT:
            begin
                want = (w.ticks == 16'd0) ? 1 : int'(w.ticks);
                if (list_count >= MAX_ENTRIES)
                    res.status = ST_FULL;
                else
                begin
                    pos = 0;
                    sum = 0;
                    while (pos < list_count && sum + int'(list_delta[pos]) <= want)
                    begin
                        sum += int'(list_delta[pos]);
                        pos++;
                    end
                    nd = want - sum;
                    if (pos < list_count)
                        list_delta[pos] = list_delta[pos] - 16'(nd);
                    for (int i = list_count; i > pos; i--)
                    begin
                        list_thread[i] = list_thread[i - 1];
                        list_delta[i]  = list_delta[i - 1];
                    end
                    list_thread[pos] = w.id;
                    list_delta[pos]  = 16'(nd);
                    list_count++;
                end
                results_due.push_back(res);
            end
            OP_REMOVE:
            begin
                res.status = ST_NOT_FOUND;
                for (pos = 0; pos < list_count; pos++)
                begin
                    if (list_thread[pos] == w.id)
                        break;
                end
                if (pos < list_count)
                begin
                    if (pos + 1 < list_count)
                    begin
                        merged = int'(list_delta[pos + 1]) + int'(list_delta[pos]);
                        list_delta[pos + 1] = (merged > 65535) ? 16'hFFFF : 16'(merged);
                    end
                    drop_entry(pos);
                    res.status = ST_OK;
                end
                results_due.push_back(res);
            end
            OP_TICK:
            begin
                n = 0;
                if (list_count > 0 && list_delta[0] != 16'd0)
                    list_delta[0] = list_delta[0] - 16'd1;
                // A woken word is queued only once it is known whether another follows.
                while (n < MAX_RESULTS && list_count > 0 && list_delta[0] == 16'd0)
                begin
                    if (n > 0)
                        results_due.push_back(res);
                    res = '{id: list_thread[0], woke: 1'b1, status: ST_OK, last: 1'b0};
                    drop_entry(0);
                    n++;
                end
                res.last = 1'b1;
                results_due.push_back(res);
            end
            default:
                results_due.push_back(res);
        endcase
    endfunction

    function void queue_word(dsq_op_t op, int id, int ticks);
        sleep_word_t w;
        w.op    = op;
        w.id    = 8'(id);
        w.ticks = 16'(ticks);
        words_to_send.push_back(w);
    endfunction

    function sleep_word_t random_word();
        sleep_word_t w;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 42)
            w.op = OP_INSERT;
        else if (r < 77)
            w.op = OP_TICK;
        else if (r < 95)
            w.op = OP_REMOVE;
        else
            w.op = OP_NONE;
        // A small pool of threads lets removes find their target most of the time.
        w.id = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 23))
                                            : 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (w.op != OP_INSERT || r >= 95)
            w.ticks = 16'($urandom);
        else if (r < 60)
            w.ticks = 16'($urandom_range(1, 6));
        else if (r < 85)
            w.ticks = 16'($urandom_range(0, 40));
        else if (r < 90)
            w.ticks = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        else
            w.ticks = 16'($urandom_range(100, 5000));
        return w;
    endfunction

    task report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d", what, got, want);
        mismatches++;
    endtask

    // Driver.
    always @(posedge clk)
    begin : drive
        logic fire;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            fire = s_tvalid && s_tready;
            if (fire)
            begin
                advance_sleep_queue(word_on_bus);
                send_hold = gap_cycles(send_calm);
            end
            if (fire || !s_tvalid)
            begin
                if (send_hold > 0)
                begin
                    send_hold--;
                    s_tvalid <= 1'b0;
                end
                else if (words_to_send.size() > 0)
                begin
                    word_on_bus = words_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {word_on_bus.ticks, word_on_bus.id};
                    s_tuser  <= word_on_bus.op;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor and receive-side stalls.
    always @(posedge clk)
    begin : watch
        wake_word_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (results_due.size() == 0)
                    report_mismatch("unexpected word, woken_id", m_tdata, 0);
                else
                begin
                    want = results_due.pop_front();
                    if (m_tdata != want.id)
                        report_mismatch("woken_id", m_tdata, want.id);
                    if (m_tuser[0] != want.woke)
                        report_mismatch("woke", m_tuser[0], want.woke);
                    if (m_tuser[2:1] != want.status)
                        report_mismatch("status", m_tuser[2:1], want.status);
                    if (m_tlast != want.last)
                        report_mismatch("last", m_tlast, want.last);
                end
                recv_hold = gap_cycles(recv_calm);
            end
            else if (m_tready && $urandom_range(0, 15) == 0)
                recv_hold = gap_cycles(recv_calm);
            if (recv_hold > 0)
            begin
                recv_hold--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Watchdog on handshake progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("delta_sleep_queue_top_tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        // Empty queue: tick wakes nothing, remove finds nothing, unused opcode.
        queue_word(OP_TICK, 8'h00, 16'h0000);
        queue_word(OP_REMOVE, 8'h05, 16'hFFFF);
        queue_word(OP_NONE, 8'hFF, 16'hFFFF);
        // Fill the queue with equal wake times; the first asks for zero ticks.
        for (int i = 0; i < MAX_ENTRIES; i++)
            queue_word(OP_INSERT, i * 17, (i == 0) ? 0 : 1);
        queue_word(OP_INSERT, 8'h5A, 16'hFFFF);
        queue_word(OP_REMOVE, 8'h03, 16'h0000);
        queue_word(OP_REMOVE, 8'd17, 16'h0000);
        // One tick now wakes every remaining thread.
        queue_word(OP_TICK, 8'hAA, 16'h5555);
        // Duplicate threads: remove takes the earliest one.
        queue_word(OP_INSERT, 8'd200, 16'hFFFF);
        queue_word(OP_INSERT, 8'd201, 16'd100);
        queue_word(OP_INSERT, 8'd200, 16'hFFFF);
        queue_word(OP_REMOVE, 8'd200, 16'h0000);
        queue_word(OP_TICK, 8'h55, 16'hAAAA);
        queue_word(OP_REMOVE, 8'd200, 16'h0000);
        for (int i = 0; i < RANDOM_WORDS; i++)
            words_to_send.push_back(random_word());

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (words_to_send.size() > 0 || s_tvalid || results_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && results_due.size() == 0)
            $display("delta_sleep_queue_top_tb OK");
        else
            $display("delta_sleep_queue_top_tb NOT OK");
        $finish;
    end

endmodule

### files.f
design/dsq_pkg.sv
design/dsq_ctrl.sv
design/dsq_datapath.sv
design/delta_sleep_queue_top.sv
verif/delta_sleep_queue_top_tb.sv
